// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int unsigned MAX_PAGES_DEF  = 32768;
   localparam int unsigned PAGE_BYTES_DEF = 4096;
   localparam logic [31:0] BASE_RESET     = 32'h0040_0000;
   localparam logic [15:0] PAGES_RESET    = 16'd31744;

   localparam logic [1:0] OP_ALLOC_LO = 2'd0;
   localparam logic [1:0] OP_ALLOC_HI = 2'd1;
   localparam logic [1:0] OP_FREE     = 2'd2;
   localparam logic [1:0] OP_RESERVE  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_ALIGN    = 3'd3;
   localparam logic [2:0] ST_PAST_END = 3'd4;

   localparam logic [0:0] REG_BASE  = 1'd0;
   localparam logic [0:0] REG_PAGES = 1'd1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MARK,
      S_FREE,
      S_RESP
   } state_type;

endpackage

// ===== rtl/bpa_map.sv =====
// ----------------------------------------------------------------------------
// bpa_map
// Page used-map: one-bit-wide synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module bpa_map #(
   parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
   localparam int unsigned AW = $clog2(MAX_PAGES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [MAX_PAGES];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator over a one-bit-per-page map with a next-fit pointer.
// ----------------------------------------------------------------------------
// One request at a time. The map is a single-port-read, single-port-write
// memory. A scan examines each page in a read state and then a check state.
// A single-page low allocation marks its page in the check state; any other
// allocation marks its run one page at a time in a mark state. Free clears
// the in-area pages of its range one at a time. Reserve checks its range in
// one state, then sets its pages one at a time. Every request ends in a
// response state that raises the result beat. After reset a clearing pass
// writes every map entry; no request is taken during it (the configuration port works).
module bitmap_page_allocator #(
   parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
   parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // address[31:0], page_count[47:32]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_address[31:0], status[34:32], zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned AW = $clog2(MAX_PAGES);
   localparam int unsigned OW = $clog2(PAGE_BYTES);
   localparam int unsigned CW = AW + 1;
   // loop index also walks a free range of up to 65535 pages
   localparam int unsigned KW = (CW > 16) ? CW : 16;

   // configuration
   logic [31:0] base_ff;
   logic [15:0] pages_ff;
   logic        wr_cfg;
   assign csr_pready = 1'b1;
   assign wr_cfg = csr_psel & csr_penable & csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= bpa_pkg::BASE_RESET;
         pages_ff <= bpa_pkg::PAGES_RESET;
      end else if (wr_cfg && csr_paddr[2] == bpa_pkg::REG_BASE) begin
         base_ff <= csr_pwdata;
      end else if (wr_cfg && csr_paddr[2] == bpa_pkg::REG_PAGES) begin
         pages_ff <= csr_pwdata[15:0];
      end
   end
   always_comb begin
      if (csr_paddr[2] == bpa_pkg::REG_BASE) csr_prdata = base_ff;
      else csr_prdata = {16'd0, pages_ff};
   end

   // effective values
   logic [CW-1:0] p_eff;
   logic [31:0]   lo32;
   always_comb begin
      if ({16'd0, pages_ff} > 32'(MAX_PAGES)) p_eff = CW'(MAX_PAGES);
      else p_eff = CW'(pages_ff);
      lo32 = {base_ff[31:OW], {OW{1'b0}}};
   end

   // request registers
   bpa_pkg::state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   addr_ff, addr_in;
   logic [15:0]   n_ff, n_in;
   logic [KW-1:0] k_ff, k_in;       // scan step / loop index
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] pg_ff, pg_in;     // current page
   logic [CW-1:0] nf_ff, nf_in;
   logic [CW-1:0] start_ff, start_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [31:0]   res_ff, res_in;
   logic [2:0]    st_ff, st_in;
   logic          vld_ff, vld_in;

   logic          m_we, m_wd, m_rd;
   logic [AW-1:0] m_wa, m_ra;

   bpa_map #(.MAX_PAGES(MAX_PAGES)) u_map (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd)
   );

   // wide range arithmetic for free / reserve
   logic [32:0] hi33, a33, pgoff33;
   logic [47:0] cnt_bytes;
   always_comb begin
      hi33      = {1'b0, lo32} + (33'(p_eff) << OW);
      a33       = {1'b0, addr_ff};
      cnt_bytes = 48'(n_ff) << OW;
      pgoff33   = a33 - {1'b0, lo32};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_CLEAR;
         clr_ff   <= '0;
         nf_ff    <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nf_ff    <= nf_in;
         vld_ff   <= vld_in;
      end
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      run_ff   <= run_in;
      pg_ff    <= pg_in;
      start_ff <= start_in;
      res_ff   <= res_in;
      st_ff    <= st_in;
   end

   logic          single;
   logic [CW:0]   wrap;
   logic [CW-1:0] runn;
   logic [31:0]   hit_addr;
   logic [32:0]   fa;
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; addr_in = addr_ff; n_in = n_ff; k_in = k_ff;
      run_in = run_ff; pg_in = pg_ff; nf_in = nf_ff; start_in = start_ff;
      clr_in = clr_ff; res_in = res_ff; st_in = st_ff; vld_in = vld_ff;
      m_we = 1'b0; m_wd = 1'b0; m_wa = '0; m_ra = pg_ff[AW-1:0];
      req_tready = 1'b0;
      single = (op_ff == bpa_pkg::OP_ALLOC_LO) && (n_ff == 16'd1);
      wrap = '0; runn = '0; hit_addr = '0; fa = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         bpa_pkg::S_CLEAR: begin
            m_we = 1'b1; m_wa = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(MAX_PAGES - 1)) state_in = bpa_pkg::S_IDLE;
         end
         bpa_pkg::S_IDLE: begin
            req_tready = !vld_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               op_in = req_tuser; addr_in = req_tdata[31:0]; n_in = req_tdata[47:32];
               k_in = '0; run_in = '0; res_in = '0; st_in = bpa_pkg::ST_OK;
               case (req_tuser)
                  bpa_pkg::OP_ALLOC_LO, bpa_pkg::OP_ALLOC_HI: begin
                     if (req_tdata[47:32] == 16'd0 || 32'(req_tdata[47:32]) > 32'(p_eff)) begin
                        st_in = bpa_pkg::ST_NO_SPACE; state_in = bpa_pkg::S_RESP;
                     end else begin
                        state_in = bpa_pkg::S_SCAN_RD;
                        if (req_tuser == bpa_pkg::OP_ALLOC_HI) pg_in = p_eff - 1'b1;
                        else if (req_tdata[47:32] == 16'd1)
                           pg_in = (nf_ff < p_eff) ? nf_ff : '0;
                        else pg_in = '0;
                     end
                  end
                  bpa_pkg::OP_FREE: begin
                     if (req_tdata[OW-1:0] == '0 && req_tdata[47:32] != 16'd0)
                        state_in = bpa_pkg::S_FREE;
                     else state_in = bpa_pkg::S_RESP;
                  end
                  default: state_in = bpa_pkg::S_RESP; // reserve of zero pages
               endcase
               if (req_tuser == bpa_pkg::OP_RESERVE && req_tdata[47:32] != 16'd0)
                  state_in = bpa_pkg::S_FREE;
            end
         end
         bpa_pkg::S_SCAN_RD: begin
            m_ra = pg_ff[AW-1:0];
            state_in = bpa_pkg::S_SCAN_CHK;
         end
         bpa_pkg::S_SCAN_CHK: begin
            hit_addr = lo32 + (32'(pg_ff) << OW);
            runn = run_ff + 1'b1;
            k_in = k_ff + 1'b1;
            state_in = bpa_pkg::S_SCAN_RD;
            if (single) begin
               if (!m_rd) begin
                  m_we = 1'b1; m_wa = pg_ff[AW-1:0]; m_wd = 1'b1;
                  nf_in = (pg_ff + 1'b1 >= p_eff) ? '0 : pg_ff + 1'b1;
                  res_in = hit_addr; state_in = bpa_pkg::S_RESP;
               end else begin
                  wrap = {1'b0, pg_ff} + 1'b1;
                  pg_in = (wrap >= {1'b0, p_eff}) ? '0 : wrap[CW-1:0];
               end
            end else if (!m_rd && runn == CW'(n_ff)) begin
               start_in = (op_ff == bpa_pkg::OP_ALLOC_HI) ? pg_ff : pg_ff + 1'b1 - CW'(n_ff);
               res_in = (op_ff == bpa_pkg::OP_ALLOC_HI) ? hit_addr
                        : lo32 + (32'(pg_ff + 1'b1 - CW'(n_ff)) << OW);
               k_in = '0; state_in = bpa_pkg::S_MARK;
            end else begin
               run_in = m_rd ? '0 : runn;
               pg_in = (op_ff == bpa_pkg::OP_ALLOC_HI) ? pg_ff - 1'b1 : pg_ff + 1'b1;
            end
            if (state_in == bpa_pkg::S_SCAN_RD && 32'(k_ff) + 32'd1 >= 32'(p_eff)) begin
               st_in = bpa_pkg::ST_NO_SPACE; state_in = bpa_pkg::S_RESP;
            end
         end
         bpa_pkg::S_MARK: begin
            m_we = 1'b1; m_wd = 1'b1; m_wa = AW'(start_ff) + AW'(k_ff);
            k_in = k_ff + 1'b1;
            if (32'(k_ff) + 32'd1 == 32'(n_ff)) state_in = bpa_pkg::S_RESP;
         end
         bpa_pkg::S_FREE: begin
            if (op_ff == bpa_pkg::OP_FREE) begin
               fa = 33'(a33 + (33'(k_ff) << OW));
               if (fa >= {1'b0, lo32} && fa < hi33) begin
                  m_we = 1'b1; m_wd = 1'b0;
                  m_wa = AW'((fa - {1'b0, lo32}) >> OW);
               end
               k_in = k_ff + 1'b1;
               if (32'(k_ff) + 32'd1 >= 32'(n_ff)) state_in = bpa_pkg::S_RESP;
               // freeing beyond the 33-bit window can never hit the area
            end else begin
               if (a33 < {1'b0, lo32} || a33 >= hi33) begin
                  st_in = bpa_pkg::ST_RANGE; state_in = bpa_pkg::S_RESP;
               end else if (addr_ff[OW-1:0] != '0) begin
                  st_in = bpa_pkg::ST_ALIGN; state_in = bpa_pkg::S_RESP;
               end else if (({15'd0, a33} + cnt_bytes) > {15'd0, hi33}) begin
                  st_in = bpa_pkg::ST_PAST_END; state_in = bpa_pkg::S_RESP;
               end else begin
                  start_in = CW'(pgoff33 >> OW); k_in = '0;
                  state_in = bpa_pkg::S_MARK;
               end
            end
         end
         bpa_pkg::S_RESP: begin
            if (!vld_ff || rsp_tready) begin
               vld_in = 1'b1; state_in = bpa_pkg::S_IDLE;
            end
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {5'd0, st_ff, res_ff};

endmodule

// ===== rtl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the bitmap page allocator.
// ----------------------------------------------------------------------------
module bpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= bpa_pkg::ST_PAST_END)
      else $error("status code out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] != bpa_pkg::ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("failed request carries an address");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_pready(csr_pready)
);

// ===== dv/bitmap_page_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Self-checking bench: requests are generated phase by phase, each phase under
// its own base address and page count; a page-map predictor works out the
// expected beat for every request and the response stream is checked in order.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;

   localparam int unsigned NPAGES   = bpa_pkg::MAX_PAGES_DEF;
   localparam int unsigned PG_BYTES = bpa_pkg::PAGE_BYTES_DEF;
   localparam logic [31:0] OFS_MASK = PG_BYTES - 1;
   localparam int          LIMIT    = 3000000;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] addr;
      logic [15:0] count;
   } page_req_type;

   typedef struct {
      logic [31:0] addr;
      logic [2:0]  status;
   } alloc_rsp_type;

   typedef struct {
      logic [31:0] addr;
      logic [15:0] count;
   } run_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;   // address[31:0], page_count[47:32]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid, rsp_tready;
   logic [39:0] rsp_tdata;   // result_address[31:0], status[34:32], zero
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   bitmap_page_allocator u_dut (.*);

   // predictor state
   bit          used_map [0:NPAGES-1];
   int unsigned next_fit;
   logic [31:0] cfg_base;
   logic [15:0] cfg_pages;

   page_req_type  req_q[$];
   alloc_rsp_type pend_q[$];
   alloc_rsp_type rsp_q[$];
   run_type       taken_q[$];
   alloc_rsp_type cur_rsp;
   logic          req_fire;
   int            gap_left, stall_left, beats_sent;
   bit            no_idle;
   int            errors;
   int            cycles;
   int            added, checked;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned live_pages();
      return (cfg_pages > NPAGES) ? NPAGES : cfg_pages;
   endfunction

   function automatic alloc_rsp_type predict_alloc(page_req_type r);
      alloc_rsp_type    res;
      int unsigned      p, nf, pg, run, k, i, start;
      longint unsigned  lo, hi, a;
      bit               found;
      p   = live_pages();
      lo  = {32'd0, cfg_base & ~OFS_MASK};
      hi  = lo + longint'(p) * PG_BYTES;
      res.addr   = '0;
      res.status = bpa_pkg::ST_OK;
      case (r.op)
         bpa_pkg::OP_ALLOC_LO, bpa_pkg::OP_ALLOC_HI: begin
            if (r.count == 0 || r.count > p) begin
               res.status = bpa_pkg::ST_NO_SPACE;
            end else if (r.op == bpa_pkg::OP_ALLOC_LO && r.count == 1) begin
               nf = (next_fit < p) ? next_fit : 0;
               res.status = bpa_pkg::ST_NO_SPACE;
               for (i = 0; i < p; i++) begin
                  pg = nf + i;
                  if (pg >= p) pg -= p;
                  if (!used_map[pg]) begin
                     used_map[pg] = 1;
                     next_fit     = (pg + 1 >= p) ? 0 : pg + 1;
                     res.addr     = 32'(lo + longint'(pg) * PG_BYTES);
                     res.status   = bpa_pkg::ST_OK;
                     break;
                  end
               end
            end else begin
               found = 0;
               run   = 0;
               start = 0;
               for (k = 0; k < p && !found; k++) begin
                  i = (r.op == bpa_pkg::OP_ALLOC_HI) ? p - 1 - k : k;
                  if (used_map[i]) run = 0;
                  else begin
                     run++;
                     if (run == r.count) begin
                        found = 1;
                        start = (r.op == bpa_pkg::OP_ALLOC_HI) ? i : i + 1 - r.count;
                     end
                  end
               end
               if (found) begin
                  for (i = 0; i < r.count; i++) used_map[start + i] = 1;
                  res.addr = 32'(lo + longint'(start) * PG_BYTES);
               end else begin
                  res.status = bpa_pkg::ST_NO_SPACE;
               end
            end
         end
         bpa_pkg::OP_FREE: begin
            if ((r.addr & OFS_MASK) == 0) begin
               for (i = 0; i < r.count; i++) begin
                  a = longint'(r.addr) + longint'(i) * PG_BYTES;
                  if (a >= lo && a < hi) used_map[(a - lo) / PG_BYTES] = 0;
               end
            end
         end
         default: begin
            if (r.count != 0) begin
               a = {32'd0, r.addr};
               if (a < lo || a >= hi) res.status = bpa_pkg::ST_RANGE;
               else if ((r.addr & OFS_MASK) != 0) res.status = bpa_pkg::ST_ALIGN;
               else if (a + longint'(r.count) * PG_BYTES > hi)
                  res.status = bpa_pkg::ST_PAST_END;
               else begin
                  for (i = 0; i < r.count; i++) used_map[(a - lo) / PG_BYTES + i] = 1;
               end
            end
         end
      endcase
      return res;
   endfunction

   task automatic add_req(logic [1:0] op, logic [31:0] addr, logic [15:0] count);
      page_req_type  r;
      alloc_rsp_type e;
      run_type       t;
      r.op = op;
      r.addr = addr;
      r.count = count;
      e = predict_alloc(r);
      if ((op == bpa_pkg::OP_ALLOC_LO || op == bpa_pkg::OP_ALLOC_HI) &&
          e.status == bpa_pkg::ST_OK) begin
         t.addr  = e.addr;
         t.count = count;
         taken_q.push_back(t);
      end
      req_q.push_back(r);
      pend_q.push_back(e);
      added++;
   endtask

   // mostly alloc/free pairs over live runs, plus reserves and noise
   task automatic add_random(int unsigned cap);
      int unsigned p, r, idx, n;
      logic [31:0] lo, a;
      logic [1:0]  op;
      p  = live_pages();
      lo = cfg_base & ~OFS_MASK;
      r  = $urandom_range(0, 99);
      if (r < 40) begin
         op = $urandom_range(0, 1) ? bpa_pkg::OP_ALLOC_HI : bpa_pkg::OP_ALLOC_LO;
         r  = $urandom_range(0, 99);
         if (cap != 0) n = $urandom_range(1, cap);
         else if (r < 55) n = 1;
         else if (r < 90) n = $urandom_range(1, p / 4 + 1);
         else if (r < 95) n = $urandom_range(0, p + 2);
         else n = $urandom_range(0, 65535);
         add_req(op, $urandom, 16'(n));
      end else if (r < 70 && taken_q.size() > 0) begin
         idx = $urandom_range(0, taken_q.size() - 1);
         add_req(bpa_pkg::OP_FREE, taken_q[idx].addr, taken_q[idx].count);
         taken_q.delete(idx);
      end else if (r < 85) begin
         a = lo + $urandom_range(0, p + 1) * PG_BYTES;
         if ($urandom_range(0, 7) == 0) a += $urandom_range(1, PG_BYTES - 1);
         n = $urandom_range(0, (cap != 0) ? cap : 4);
         add_req(bpa_pkg::OP_RESERVE, a, 16'(n));
      end else begin
         n = $urandom_range(0, (cap != 0) ? cap : 300);
         add_req(2'($urandom_range(0, 3)), $urandom, 16'(n));
      end
   endtask

   task automatic csr_write(logic [0:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      if (idx == bpa_pkg::REG_BASE) cfg_base = value;
      else cfg_pages = value[15:0];
   endtask

   // every queued request has had its result beat checked
   task automatic drain();
      while (checked < added) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] base, logic [15:0] pages, int items,
                            int unsigned cap);
      csr_write(bpa_pkg::REG_BASE, base);
      csr_write(bpa_pkg::REG_PAGES, pages);
      taken_q.delete();
      repeat (items) add_random(cap);
      drain();
   endtask

   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 0;
         end else if (req_q.size() > 0) begin
            page_req_type r;
            r       = req_q.pop_front();
            cur_rsp = pend_q.pop_front();
            req_tdata  <= {r.count, r.addr};
            req_tuser  <= r.op;
            req_tvalid <= 1;
            beats_sent++;
            if (beats_sent % 97 == 0) no_idle = ($urandom_range(0, 3) == 0);
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         stall_left = pick_gap();
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      alloc_rsp_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) rsp_q.push_back(cur_rsp);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %h", rsp_tdata);
         end else begin
            e = rsp_q.pop_front();
            checked++;
            if (rsp_tdata[31:0] !== e.addr || rsp_tdata[34:32] !== e.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: addr exp %h got %h, status exp %0d got %0d",
                           e.addr, rsp_tdata[31:0], e.status, rsp_tdata[34:32]);
            end
         end
      end
   end

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_fire    = 0;
      gap_left    = 0;
      stall_left  = 0;
      beats_sent  = 0;
      no_idle     = 0;
      errors      = 0;
      cycles      = 0;
      added       = 0;
      checked     = 0;
      next_fit    = 0;
      cfg_base    = bpa_pkg::BASE_RESET;
      cfg_pages   = bpa_pkg::PAGES_RESET;
      foreach (used_map[i]) used_map[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, under the reset configuration
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd0);
      add_req(bpa_pkg::OP_ALLOC_HI, 32'hFFFF_FFFF, 16'd0);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd1);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd1);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd3);
      add_req(bpa_pkg::OP_ALLOC_HI, 32'h0, 16'd2);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd31745);
      add_req(bpa_pkg::OP_ALLOC_HI, 32'h0, 16'hFFFF);
      add_req(bpa_pkg::OP_FREE, 32'h0040_1001, 16'd1);      // unaligned frees nothing
      add_req(bpa_pkg::OP_FREE, 32'h0040_1000, 16'd0);
      add_req(bpa_pkg::OP_FREE, 32'h0040_1000, 16'd1);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd1);
      add_req(bpa_pkg::OP_RESERVE, 32'h0040_8000, 16'd0);
      add_req(bpa_pkg::OP_RESERVE, 32'h003F_F000, 16'd1);
      add_req(bpa_pkg::OP_RESERVE, 32'hFFFF_F000, 16'd1);
      add_req(bpa_pkg::OP_RESERVE, 32'h0040_8800, 16'd1);
      add_req(bpa_pkg::OP_RESERVE, 32'h07FF_F000, 16'd2);   // last page, runs past end
      add_req(bpa_pkg::OP_RESERVE, 32'h0040_8000, 16'd4);
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd2);
      add_req(bpa_pkg::OP_FREE, 32'h0000_0000, 16'hFFFF);   // spans below and into the area
      add_req(bpa_pkg::OP_ALLOC_LO, 32'h0, 16'd1);
      drain();

      run_phase(32'h0000_0000, 16'd1, 60, 0);       // next-fit left beyond the area
      run_phase($urandom, 16'd0, 20, 0);
      run_phase(32'h0000_7000, 16'hFFFF, 20, 4);    // clamped to the full map
      run_phase(32'hFFFF_FFFF, 16'd16, 80, 0);      // address wrap at the top
      repeat (8) run_phase($urandom, 16'($urandom_range(2, 64)), 206, 0);

      drain();
      repeat (20) @(posedge clock);
      if (rsp_q.size() != 0) errors++;
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
